/* rtl/knnlm_pkg.sv */
// ----------------------------------------------------------------------------
// knnlm_pkg
// Shared constants and types for the k-nearest-neighbor list merge block.
// ----------------------------------------------------------------------------
package knnlm_pkg;

  localparam int MAX_K       = 32;
  localparam int MAX_ENTRIES = 64;

  localparam int ID_W   = 31;
  localparam int DIST_W = 32;
  localparam int KEY_W  = DIST_W + ID_W;
  localparam int K_W    = 6;
  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int RANK_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_K_OUT = 2'd0;
  localparam logic [K_W-1:0]    K_OUT_RESET = 6'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_SEL,
    S_SEL_END
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_issue;
    logic scan_end;
    logic sel_issue;
    logic sel_end;
    logic clear;
  } knnlm_cmd_t;

  typedef struct packed {
    logic last_in;
    logic cnt_zero;
    logic idx_last;
    logic k_zero;
    logic rank_last;
  } knnlm_sts_t;

endpackage

/* rtl/knnlm_ram.sv */
// ----------------------------------------------------------------------------
// knnlm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module knnlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/knnlm_cfg.sv */
// ----------------------------------------------------------------------------
// knnlm_cfg
// APB register slice holding k_out.
// ----------------------------------------------------------------------------
module knnlm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [knnlm_pkg::APB_AW-1:0]   paddr,
  input  logic [knnlm_pkg::APB_DW-1:0]   pwdata,
  output logic [knnlm_pkg::APB_DW-1:0]   prdata,
  output logic                           pready,
  output logic [knnlm_pkg::K_W-1:0]      k_out
);

  logic [knnlm_pkg::K_W-1:0] k_out_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == knnlm_pkg::ADDR_K_OUT);
  assign k_out  = k_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_out_r <= knnlm_pkg::K_OUT_RESET;
    end else if (wr_en) begin
      k_out_r <= pwdata[knnlm_pkg::K_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == knnlm_pkg::ADDR_K_OUT) begin
      prdata = {{(knnlm_pkg::APB_DW - knnlm_pkg::K_W){1'b0}}, k_out_r};
    end
  end

endmodule

/* rtl/knnlm_ctrl.sv */
// ----------------------------------------------------------------------------
// knnlm_ctrl
// Sequencer: duplicate scan per entry, then one selection pass per rank.
// ----------------------------------------------------------------------------
module knnlm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  knnlm_pkg::knnlm_sts_t sts,
  output knnlm_pkg::knnlm_cmd_t cmd
);

  knnlm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= knnlm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      knnlm_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.cnt_zero ? knnlm_pkg::S_SCAN_END : knnlm_pkg::S_SCAN;
        end
      end
      knnlm_pkg::S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.idx_last) begin
          state_nxt = knnlm_pkg::S_SCAN_END;
        end
      end
      knnlm_pkg::S_SCAN_END: begin
        cmd.scan_end = 1'b1;
        if (!sts.last_in) begin
          state_nxt = knnlm_pkg::S_IDLE;
        end else if (sts.k_zero) begin
          cmd.clear = 1'b1;
          state_nxt = knnlm_pkg::S_IDLE;
        end else begin
          state_nxt = knnlm_pkg::S_SEL;
        end
      end
      knnlm_pkg::S_SEL: begin
        if (sts.cnt_zero) begin
          state_nxt = knnlm_pkg::S_SEL_END;
        end else begin
          cmd.sel_issue = 1'b1;
          if (sts.idx_last) begin
            state_nxt = knnlm_pkg::S_SEL_END;
          end
        end
      end
      knnlm_pkg::S_SEL_END: begin
        cmd.sel_end = 1'b1;
        if (sts.rank_last) begin
          cmd.clear = 1'b1;
          state_nxt = knnlm_pkg::S_IDLE;
        end else begin
          state_nxt = knnlm_pkg::S_SEL;
        end
      end
      default: begin
        state_nxt = knnlm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/knnlm_dp.sv */
// ----------------------------------------------------------------------------
// knnlm_dp
// Entry store, duplicate compare, min-above-previous selection, result regs.
// ----------------------------------------------------------------------------
module knnlm_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  knnlm_pkg::knnlm_cmd_t             cmd,
  output knnlm_pkg::knnlm_sts_t             sts,
  input  logic [knnlm_pkg::ID_W-1:0]        in_nbr_id,
  input  logic [knnlm_pkg::DIST_W-1:0]      in_dist_key,
  input  logic                              in_last,
  input  logic [knnlm_pkg::K_W-1:0]         k_out,
  output logic                              out_strobe,
  output logic [knnlm_pkg::ID_W-1:0]        out_nbr_id,
  output logic [knnlm_pkg::DIST_W-1:0]      out_dist_key,
  output logic                              out_valid,
  output logic                              out_last
);

  logic [knnlm_pkg::ID_W-1:0]   id_r;
  logic [knnlm_pkg::DIST_W-1:0] dist_r;
  logic                         last_r;
  logic [knnlm_pkg::CNT_W-1:0]  count_r;
  logic [knnlm_pkg::AW-1:0]     idx_r;
  logic [knnlm_pkg::RANK_W-1:0] rank_r;
  logic                         rd_vld_r;
  logic                         seen_r;
  logic                         found_r;
  logic                         first_r;
  logic [knnlm_pkg::KEY_W-1:0]  best_r;
  logic [knnlm_pkg::KEY_W-1:0]  prev_r;
  logic                         out_strobe_r;
  logic [knnlm_pkg::KEY_W-1:0]  out_key_r;
  logic                         out_valid_r;
  logic                         out_last_r;

  logic [knnlm_pkg::KEY_W-1:0]  rd_key;
  logic                         ram_we;
  logic                         seen_fin;
  logic                         take;
  logic                         found_fin;
  logic [knnlm_pkg::KEY_W-1:0]  best_fin;
  logic [knnlm_pkg::K_W-1:0]    k_eff;

  knnlm_ram #(
    .WIDTH(knnlm_pkg::KEY_W),
    .DEPTH(knnlm_pkg::MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[knnlm_pkg::AW-1:0]),
    .wdata({dist_r, id_r}),
    .raddr(idx_r),
    .rdata(rd_key)
  );

  // duplicate check against the id read back this cycle
  assign seen_fin = seen_r || (rd_vld_r && (rd_key[knnlm_pkg::ID_W-1:0] == id_r));
  assign ram_we   = cmd.scan_end && !seen_fin &&
                    (count_r < knnlm_pkg::CNT_W'(knnlm_pkg::MAX_ENTRIES));

  // {dist, id} orders by distance, then id
  assign take      = rd_vld_r && (first_r || (rd_key > prev_r)) &&
                     (!found_r || (rd_key < best_r));
  assign found_fin = found_r || take;
  assign best_fin  = take ? rd_key : best_r;

  assign k_eff = (k_out > knnlm_pkg::K_W'(knnlm_pkg::MAX_K)) ?
                 knnlm_pkg::K_W'(knnlm_pkg::MAX_K) : k_out;

  assign sts.last_in   = last_r;
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.idx_last  = ({1'b0, idx_r} == (count_r - knnlm_pkg::CNT_W'(1)));
  assign sts.k_zero    = (k_out == '0);
  assign sts.rank_last = ((knnlm_pkg::K_W'(rank_r) + knnlm_pkg::K_W'(1)) == k_eff);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r   <= in_nbr_id;
      dist_r <= in_dist_key;
      last_r <= in_last;
    end
    if (cmd.sel_end) begin
      out_key_r   <= found_fin ? best_fin : '0;
      out_valid_r <= found_fin;
      out_last_r  <= sts.rank_last;
      if (found_fin) begin
        prev_r <= best_fin;
      end
    end else if (rd_vld_r && !cmd.scan_end) begin
      if (take) begin
        best_r <= rd_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      rank_r       <= '0;
      rd_vld_r     <= 1'b0;
      seen_r       <= 1'b0;
      found_r      <= 1'b0;
      first_r      <= 1'b1;
      out_strobe_r <= 1'b0;
    end else begin
      rd_vld_r     <= cmd.scan_issue || cmd.sel_issue;
      out_strobe_r <= cmd.sel_end;
      if (cmd.load) begin
        idx_r  <= '0;
        seen_r <= 1'b0;
      end else if (cmd.scan_issue || cmd.sel_issue) begin
        idx_r <= idx_r + knnlm_pkg::AW'(1);
      end else if (cmd.scan_end || cmd.sel_end) begin
        idx_r <= '0;
      end
      if (cmd.scan_issue) begin
        seen_r <= seen_fin;
      end
      // accumulate the running minimum of the current pass
      if (cmd.sel_issue || (rd_vld_r && !cmd.scan_end && !cmd.sel_end && !cmd.scan_issue)) begin
        found_r <= found_fin;
      end
      if (cmd.sel_end) begin
        found_r <= 1'b0;
        first_r <= 1'b0;
        rank_r  <= rank_r + knnlm_pkg::RANK_W'(1);
      end
      if (ram_we) begin
        count_r <= count_r + knnlm_pkg::CNT_W'(1);
      end
      if (cmd.clear) begin
        count_r <= '0;
        rank_r  <= '0;
        first_r <= 1'b1;
        found_r <= 1'b0;
      end
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_nbr_id   = out_key_r[knnlm_pkg::ID_W-1:0];
  assign out_dist_key = out_key_r[knnlm_pkg::KEY_W-1:knnlm_pkg::ID_W];
  assign out_valid    = out_valid_r;
  assign out_last     = out_last_r;

endmodule

/* rtl/knn_list_merge_dedup_select_core.sv */
// ----------------------------------------------------------------------------
// knn_list_merge_dedup_select_core
// Merges two neighbor lists with duplicate removal and emits the k nearest.
// ----------------------------------------------------------------------------
// An entry is taken when start is high and busy is low. Each entry is
// checked against the n unique entries already stored by reading the entry
// store one word per cycle. After the entry flagged by in_last, the block
// makes one pass over the store per result rank and pulses out_strobe once
// per result for k_out ranks (k_out above 32 acts as 32; k_out of 0 emits
// nothing). The receiver cannot stall, so every strobe must be captured;
// busy stays high until the cycle in which the final result is presented.
// Ranks beyond the number of unique ids come out with out_valid low and zero
// payload.
// ----------------------------------------------------------------------------
module knn_list_merge_dedup_select_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [knnlm_pkg::ID_W-1:0]      in_nbr_id,
  input  logic [knnlm_pkg::DIST_W-1:0]    in_dist_key,
  input  logic                            in_last,
  output logic                            out_strobe,
  output logic [knnlm_pkg::ID_W-1:0]      out_nbr_id,
  output logic [knnlm_pkg::DIST_W-1:0]    out_dist_key,
  output logic                            out_valid,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [knnlm_pkg::APB_AW-1:0]    paddr,
  input  logic [knnlm_pkg::APB_DW-1:0]    pwdata,
  output logic [knnlm_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  knnlm_pkg::knnlm_cmd_t     cmd;
  knnlm_pkg::knnlm_sts_t     sts;
  logic [knnlm_pkg::K_W-1:0] k_out;

  knnlm_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .k_out  (k_out)
  );

  knnlm_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  knnlm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_nbr_id   (in_nbr_id),
    .in_dist_key (in_dist_key),
    .in_last     (in_last),
    .k_out       (k_out),
    .out_strobe  (out_strobe),
    .out_nbr_id  (out_nbr_id),
    .out_dist_key(out_dist_key),
    .out_valid   (out_valid),
    .out_last    (out_last)
  );

endmodule
